### hdl/fisn_pkg.sv
// Package for the fast inverse square root normalizer.
// Holds float constants and the single precision multiply and add functions.
// No dependencies.
package fisn_pkg;

  localparam logic [31:0] RSQRT_MAGIC = 32'h5f3759df;
  localparam logic [31:0] CANON_NAN   = 32'h7fc00000;
  localparam logic [31:0] F_ONE_HALF  = 32'h3fc00000;  // 1.5
  localparam logic [31:0] F_HALF      = 32'h3f000000;  // 0.5

  // Flush a denormal operand to a signed zero.
  function automatic logic [31:0] ftz(input logic [31:0] a);
    if (a[30:23] == 8'd0) return {a[31], 31'd0};
    return a;
  endfunction

  // Round a normalized 24-bit significand with guard and sticky, pack it.
  // The exponent is biased and held wide so overflow and underflow show.
  function automatic logic [31:0] fpack(input logic sgn, input logic signed [10:0] ex,
                                        input logic [23:0] man, input logic g,
                                        input logic st);
    logic [24:0] rm;
    logic signed [10:0] e2;
    // Just below the smallest normal, rounding on the denormal grid reaches
    // the smallest normal when the significand is all ones.
    if ((ex == 11'sd0) && (man == 24'hffffff)) return {sgn, 8'd1, 23'd0};
    rm = {1'b0, man} + {24'd0, g & (st | man[0])};
    e2 = ex;
    if (rm[24]) begin
      rm = rm >> 1;
      e2 = ex + 11'sd1;
    end
    if (e2 >= 11'sd255) return {sgn, 8'hff, 23'd0};
    if (e2 <= 11'sd0) return {sgn, 31'd0};
    return {sgn, e2[7:0], rm[22:0]};
  endfunction

  // Single precision multiply, nearest even, denormals flushed.
  function automatic logic [31:0] fmul(input logic [31:0] a_in, input logic [31:0] b_in);
    logic [31:0] a, b;
    logic sgn, an, bn, ai, bi, az, bz;
    logic [47:0] p;
    logic signed [10:0] ex;
    logic [23:0] man;
    logic g, st;
    a = ftz(a_in);
    b = ftz(b_in);
    sgn = a[31] ^ b[31];
    an = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    bn = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    ai = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    bi = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    az = a[30:23] == 8'd0;
    bz = b[30:23] == 8'd0;
    p = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    ex = 11'(a[30:23]) + 11'(b[30:23]) - 11'sd127;
    if (p[47]) begin
      man = p[47:24];
      g = p[23];
      st = |p[22:0];
      ex = ex + 11'sd1;
    end else begin
      man = p[46:23];
      g = p[22];
      st = |p[21:0];
    end
    if (an || bn || (ai && bz) || (bi && az)) return CANON_NAN;
    if (ai || bi) return {sgn, 8'hff, 23'd0};
    if (az || bz) return {sgn, 31'd0};
    return fpack(sgn, ex, man, g, st);
  endfunction

  // Single precision add, nearest even, denormals flushed.
  function automatic logic [31:0] fadd(input logic [31:0] a_in, input logic [31:0] b_in);
    logic [31:0] a, b, t;
    logic [27:0] ma, mb, sum;
    logic [7:0] d;
    logic sgn, stk;
    logic signed [10:0] ex;
    logic [4:0] lz;
    logic found;
    a = ftz(a_in);
    b = ftz(b_in);
    if (a[30:0] < b[30:0]) begin
      t = a;
      a = b;
      b = t;
    end
    if ((a[30:23] == 8'hff) && (a[22:0] != 23'd0)) return CANON_NAN;
    if ((b[30:23] == 8'hff) && (b[22:0] != 23'd0)) return CANON_NAN;
    if (a[30:23] == 8'hff) begin
      if ((b[30:23] == 8'hff) && (a[31] != b[31])) return CANON_NAN;
      return a;
    end
    if (b[30:23] == 8'd0) begin
      if (a[30:23] == 8'd0) return {a[31] & b[31], 31'd0};
      return a;
    end
    // Significands with three low bits for guard, round and sticky.
    ma = {1'b0, 1'b1, a[22:0], 3'd0};
    mb = {1'b0, 1'b1, b[22:0], 3'd0};
    d = a[30:23] - b[30:23];
    stk = 1'b0;
    if (d > 8'd27) begin
      stk = 1'b1;
      mb = 28'd0;
    end else begin
      for (int i = 0; i < 28; i++) begin
        if (i < 32'(d) && mb[i]) stk = 1'b1;
      end
      mb = mb >> d;
    end
    mb[0] = mb[0] | stk;
    sgn = a[31];
    if (a[31] == b[31]) sum = ma + mb;
    else sum = ma - mb;
    if (sum == 28'd0) return 32'd0;
    ex = 11'(a[30:23]);
    if (sum[27]) begin
      stk = sum[0];
      sum = sum >> 1;
      sum[0] = sum[0] | stk;
      ex = ex + 11'sd1;
    end else begin
      lz = 5'd0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
        if (!found && sum[i]) begin
          found = 1'b1;
          lz = 5'(26 - i);
        end
      end
      sum = sum << lz;
      ex = ex - 11'(lz);
    end
    return fpack(sgn, ex, sum[26:3], sum[2], |sum[1:0]);
  endfunction

endpackage

### hdl/fisn_stage.sv
// One pipeline register stage with valid bit and stall handling.
// Does not depend on fisn_pkg; generic over the payload width.
module fisn_stage #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);
  // Load when the stage moves; valid is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= in_data;
    end
  end
endmodule

### hdl/fast_inverse_sqrt_normalize_core.sv
// Top level of the fast inverse square root vector normalizer.
// Uses fisn_pkg arithmetic functions and fisn_stage pipeline registers.
//
//   channel   | handshake          | payload
//   in        | in_valid/in_stall  | vec_x vec_y vec_z vec_w
//   out       | out_valid/out_stall| unit_x unit_y unit_z unit_w
//   cfg       | cfg_valid/cfg_ready| cfg_data (two_newton_steps)
//
// One item per cycle while the output is not stalled; an item passes 14 register
// stages before it can be taken. Each stage has at most one float operation on
// any path. Two Newton steps are always computed; the register selects which result
// is used. Reset clears all valid bits and the register. A stall at the output
// while a result waits there freezes the whole pipeline; nothing is lost or repeated.
module fast_inverse_sqrt_normalize_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] vec_x,
  input  logic [31:0] vec_y,
  input  logic [31:0] vec_z,
  input  logic [31:0] vec_w,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] unit_x,
  output logic [31:0] unit_y,
  output logic [31:0] unit_z,
  output logic [31:0] unit_w,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import fisn_pkg::*;

  localparam int NS = 14;
  localparam int PW = 4 * 32 + 3 * 32;  // x y z w, then three scratch words

  logic           v [NS+1];
  logic [PW-1:0]  d [NS+1];
  logic [PW-1:0]  f [NS];
  logic           en;
  logic           two_newton_steps;

  // Whole-pipe advance: the last stage empties or is taken.
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      two_newton_steps <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      two_newton_steps <= cfg_data;
    end
  end

  assign v[0] = in_valid;
  assign d[0] = {ftz(vec_x), ftz(vec_y), ftz(vec_z), vec_w, 96'd0};

  // 1.5 - t
  function automatic logic [31:0] fsub1(input logic [31:0] t);
    return fadd(F_ONE_HALF, {~t[31], t[30:0]});
  endfunction

  // Per-stage float work. Words: [223:192] x, [191:160] y, [159:128] z,
  // [127:96] w, then scratch a [95:64], b [63:32], c [31:0].
  always_comb begin
    logic [31:0] x, y, z, w, a, b, c, sh, e1;
    for (int s = 0; s < NS; s++) begin
      sh = '0;
      e1 = '0;
      {x, y, z, w, a, b, c} = d[s];
      case (s)
        0: begin
          a = fmul(x, x);
          b = fmul(y, y);
          c = fmul(z, z);
        end
        1: a = fadd(a, b);
        2: begin
          a = fadd(a, c);  // squared length
        end
        3: begin
          sh = {a[31], a[31:1]};
          b = fmul(a, F_HALF);                  // half
          c = ftz(RSQRT_MAGIC - sh);            // estimate
          if ((c[30:23] == 8'hff) && (c[22:0] != 23'd0)) c = CANON_NAN;
        end
        4: a = fmul(b, c);
        5: a = fmul(a, c);
        6: a = fsub1(a);
        7: c = fmul(c, a);                      // after one step
        8: a = fmul(b, c);
        9: a = fmul(a, c);
        10: a = fsub1(a);
        11: begin
          e1 = fmul(c, a);
          if (two_newton_steps) c = e1;
        end
        12: begin
          a = fmul(x, c);
          b = fmul(y, c);
        end
        default: begin
          c = fmul(z, c);
        end
      endcase
      f[s] = {x, y, z, w, a, b, c};
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_pipe
    fisn_stage #(.W(PW)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v[g]),
      .in_data  (f[g]),
      .out_valid(v[g+1]),
      .out_data (d[g+1])
    );
  end

  assign out_valid = v[NS];
  assign unit_x    = d[NS][95:64];
  assign unit_y    = d[NS][63:32];
  assign unit_z    = d[NS][31:0];
  assign unit_w    = d[NS][127:96];
endmodule

### hdl/fisn_checker.sv
// Port-level checker for the normalizer, bound to the top level.
// Depends only on the top level's ports.
module fisn_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] unit_x,
  input logic [31:0] unit_w
);
  // A stall at the output holds back the input too.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall) else $error("input taken while output stalled");

  // Without an output stall the input is never stalled.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall) else $error("input stalled without cause");

  // No result right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(unit_x) && $stable(unit_w))
    else $error("stalled item changed");
endmodule

bind fast_inverse_sqrt_normalize_core fisn_checker u_fisn_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .unit_x(unit_x), .unit_w(unit_w)
);
